FILE: design/mbrf_pkg.sv
// ----------------------------------------------------------------------------
// mbrf_pkg: shared types and constants
// Operation codes, mode encodings and bank lookup types for the banked
// register file.
// ----------------------------------------------------------------------------
package mbrf_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned MODE_W = 5;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned IDX_W  = 4;

	localparam logic [OP_W-1:0] OP_RDCUR  = 3'd0;
	localparam logic [OP_W-1:0] OP_WRCUR  = 3'd1;
	localparam logic [OP_W-1:0] OP_RDMODE = 3'd2;
	localparam logic [OP_W-1:0] OP_WRMODE = 3'd3;
	localparam logic [OP_W-1:0] OP_RDCPSR = 3'd4;
	localparam logic [OP_W-1:0] OP_WRCPSR = 3'd5;
	localparam logic [OP_W-1:0] OP_RDSPSR = 3'd6;
	localparam logic [OP_W-1:0] OP_WRSPSR = 3'd7;

	localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
	localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
	localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
	localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
	localparam logic [MODE_W-1:0] MODE_MON = 5'h16;
	localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
	localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
	localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

	localparam logic [IDX_W-1:0] REG_R8 = 4'd8;
	localparam logic [IDX_W-1:0] REG_SP = 4'd13;
	localparam logic [IDX_W-1:0] REG_LR = 4'd14;
	localparam logic [IDX_W-1:0] REG_PC = 4'd15;

	localparam logic       CFG_USER_MASK = 1'b0;
	localparam logic       CFG_BANKING   = 1'b1;

	localparam logic [DATA_W-1:0] CPSR_RESET      = 32'h0000_01D3;
	localparam logic [DATA_W-1:0] USER_MASK_RESET = 32'hF800_0000;

	localparam int unsigned N_LOW  = 8;
	localparam int unsigned N_HIGH = 5;
	localparam int unsigned N_BANK = 7;
	localparam int unsigned N_SPSR = 6;

	typedef logic [2:0] bank_idx_t;

	typedef struct packed {
		logic      is_fiq;
		logic      is_usr;
		logic      bank_ok;
		bank_idx_t bank;
		logic      spsr_ok;
		bank_idx_t spsr;
	} mode_info_t;

endpackage

FILE: design/mbrf_mode_map.sv
// ----------------------------------------------------------------------------
// mbrf_mode_map: mode decode
// Maps a mode encoding to its sp/lr bank and SPSR slot.
// ----------------------------------------------------------------------------
module mbrf_mode_map (
	input  logic [mbrf_pkg::MODE_W-1:0] mode,
	output mbrf_pkg::mode_info_t        info
);
	import mbrf_pkg::*;

	always_comb begin
		info = '0;
		info.is_fiq  = (mode == MODE_FIQ);
		info.is_usr  = (mode == MODE_USR);
		info.bank_ok = 1'b1;
		case (mode)
			MODE_USR: info.bank = 3'd0;
			MODE_SYS: info.bank = 3'd0;
			MODE_FIQ: info.bank = 3'd1;
			MODE_IRQ: info.bank = 3'd2;
			MODE_SVC: info.bank = 3'd3;
			MODE_ABT: info.bank = 3'd4;
			MODE_UND: info.bank = 3'd5;
			MODE_MON: info.bank = 3'd6;
			default: begin
				info.bank    = 3'd0;
				info.bank_ok = 1'b0;
			end
		endcase
		info.spsr_ok = info.bank_ok && (info.bank != 3'd0);
		info.spsr    = info.bank - 3'd1;
	end

endmodule

FILE: design/mode_banked_register_file.sv
// ----------------------------------------------------------------------------
// mode_banked_register_file: mode-banked processor register file
// Shared, FIQ-banked and per-mode registers with CPSR/SPSR access.
// ----------------------------------------------------------------------------
// Path: an input transfer passes the input register, then the result
// register. Throughput: one item per cycle while the output is not stalled,
// set by the read/update of the register store between the two registers.
// Reset: all registers 0, CPSR 0x1D3, user mask 0xF8000000, banking on.
// ----------------------------------------------------------------------------
module mode_banked_register_file (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mbrf_pkg::DATA_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mbrf_pkg::OP_W-1:0]   op,
	input  logic [mbrf_pkg::IDX_W-1:0]  reg_index,
	input  logic [mbrf_pkg::MODE_W-1:0] target_mode,
	input  logic [mbrf_pkg::DATA_W-1:0] write_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mbrf_pkg::DATA_W-1:0] read_value,
	output logic                        status
);
	import mbrf_pkg::*;

	logic [DATA_W-1:0] user_bits_mask_q;
	logic              banking_enabled_q;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [IDX_W-1:0]  reg_index_s1;
	logic [MODE_W-1:0] target_mode_s1;
	logic [DATA_W-1:0] write_value_s1;

	logic [DATA_W-1:0] low_q  [N_LOW];
	logic [DATA_W-1:0] pc_q;
	logic [DATA_W-1:0] usr_hi_q [N_HIGH];
	logic [DATA_W-1:0] fiq_hi_q [N_HIGH];
	logic [DATA_W-1:0] sp_q   [N_BANK];
	logic [DATA_W-1:0] lr_q   [N_BANK];
	logic [DATA_W-1:0] spsr_q [N_SPSR];
	logic [DATA_W-1:0] cpsr_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] read_value_q;
	logic              status_q;

	logic              s1_go;
	logic [MODE_W-1:0] cur_mode;
	logic [MODE_W-1:0] reg_mode;
	mode_info_t        cur_info;
	mode_info_t        reg_info;

	logic [DATA_W-1:0] rd_val;
	logic              rd_status;
	logic              reg_rd;
	logic              reg_wr;
	logic [DATA_W-1:0] reg_rd_val;
	logic [2:0]        low_idx;
	logic [2:0]        hi_idx;
	logic              cpsr_wr;
	logic              spsr_wr;

	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;

	assign cur_mode = cpsr_q[MODE_W-1:0];
	assign low_idx  = reg_index_s1[2:0];
	assign hi_idx   = reg_index_s1[2:0];

	always_comb begin
		reg_mode = cur_mode;
		if (op_s1 inside {OP_RDMODE, OP_WRMODE}) begin
			reg_mode = target_mode_s1;
		end
	end

	mbrf_mode_map u_cur_map (
		.mode (cur_mode),
		.info (cur_info)
	);

	mbrf_mode_map u_reg_map (
		.mode (reg_mode),
		.info (reg_info)
	);

	always_comb begin
		reg_rd_val = '0;
		if (reg_index_s1 < REG_R8) begin
			reg_rd_val = low_q[low_idx];
		end else if (reg_index_s1 < REG_SP) begin
			reg_rd_val = reg_info.is_fiq ? fiq_hi_q[hi_idx] : usr_hi_q[hi_idx];
		end else if (reg_index_s1 == REG_PC) begin
			reg_rd_val = pc_q;
		end else if (reg_info.bank_ok) begin
			reg_rd_val = (reg_index_s1 == REG_SP) ? sp_q[reg_info.bank] : lr_q[reg_info.bank];
		end
	end

	always_comb begin
		rd_val    = '0;
		rd_status = 1'b0;
		reg_rd    = 1'b0;
		reg_wr    = 1'b0;
		cpsr_wr   = 1'b0;
		spsr_wr   = 1'b0;
		case (op_s1)
			OP_RDCUR, OP_RDMODE: reg_rd = 1'b1;
			OP_WRCUR, OP_WRMODE: reg_wr = 1'b1;
			OP_RDCPSR: begin
				rd_val = banking_enabled_q ? cpsr_q : (cpsr_q & user_bits_mask_q);
			end
			OP_WRCPSR: begin
				cpsr_wr   = banking_enabled_q;
				rd_status = !banking_enabled_q;
			end
			OP_RDSPSR: begin
				rd_val = cur_info.spsr_ok ? spsr_q[cur_info.spsr] : '0;
			end
			OP_WRSPSR: begin
				if (!banking_enabled_q || cur_info.is_usr) begin
					rd_status = 1'b1;
				end else begin
					spsr_wr = cur_info.spsr_ok;
				end
			end
			default: rd_status = 1'b0;
		endcase
		if (reg_rd) begin
			rd_val = reg_rd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_bits_mask_q  <= USER_MASK_RESET;
			banking_enabled_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_USER_MASK: user_bits_mask_q  <= cfg_data;
				CFG_BANKING:   banking_enabled_q <= cfg_data[0];
				default:       banking_enabled_q <= banking_enabled_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1          <= op;
			reg_index_s1   <= reg_index;
			target_mode_s1 <= target_mode;
			write_value_s1 <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_LOW; i++) low_q[i] <= '0;
			for (int i = 0; i < N_HIGH; i++) begin
				usr_hi_q[i] <= '0;
				fiq_hi_q[i] <= '0;
			end
			for (int i = 0; i < N_BANK; i++) begin
				sp_q[i] <= '0;
				lr_q[i] <= '0;
			end
			for (int i = 0; i < N_SPSR; i++) spsr_q[i] <= '0;
			pc_q   <= '0;
			cpsr_q <= CPSR_RESET;
		end else if (s1_go) begin
			if (reg_wr) begin
				if (reg_index_s1 < REG_R8) begin
					low_q[low_idx] <= write_value_s1;
				end else if (reg_index_s1 < REG_SP) begin
					if (reg_info.is_fiq) begin
						fiq_hi_q[hi_idx] <= write_value_s1;
					end else begin
						usr_hi_q[hi_idx] <= write_value_s1;
					end
				end else if (reg_index_s1 == REG_PC) begin
					pc_q <= write_value_s1;
				end else if (reg_info.bank_ok) begin
					if (reg_index_s1 == REG_SP) begin
						sp_q[reg_info.bank] <= write_value_s1;
					end else begin
						lr_q[reg_info.bank] <= write_value_s1;
					end
				end
			end
			if (cpsr_wr) begin
				cpsr_q <= write_value_s1;
			end
			if (spsr_wr) begin
				spsr_q[cur_info.spsr] <= write_value_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			read_value_q <= rd_val;
			status_q     <= rd_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> out_valid)
		else $error("transfer lost between stage and result");

	a_cpsr_update: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && op_s1 == OP_WRCPSR && banking_enabled_q |=> cpsr_q == $past(write_value_s1))
		else $error("CPSR write not applied");

	a_user_spsr_refused: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && op_s1 == OP_WRSPSR && cur_mode == MODE_USR |=> status)
		else $error("SPSR write in user mode not refused");

endmodule
